// File: hdl/kt2d_pkg.sv
// Shared constants, types and fixed-point helpers for the 2-D Kalman tracker.
// Depends on nothing; kt2d_if, kt2d_div and the top-level tracker use it.
`default_nettype none
package kt2d_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int PREDICT_STEPS_MAX = 255;

  localparam logic signed [31:0] FX_ONE       = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] TENTH        = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [31:0] PRIOR_POS    = 32'(64'd100 << FRAC_BITS);
  localparam logic signed [31:0] MEAS_VAR_RST = 32'(64'd9 << FRAC_BITS);
  localparam logic signed [31:0] Q_POS        = 32'(64'd2 << FRAC_BITS);
  localparam logic signed [31:0] Q_VEL        = 32'((64'd7 << FRAC_BITS) / 64'd2);
  localparam logic signed [31:0] Q_ACC        = 32'(64'd4 << FRAC_BITS);

  localparam int COV_N  = 36;
  localparam int COV_AW = 6;

  localparam int DIV_NW = 33 + FRAC_BITS;
  localparam int DIV_CW = 6;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FB     = 3'd4;

  typedef enum logic [2:0] {
    OP_DT2, OP_FP, OP_FTF, OP_DET, OP_GAIN, OP_PMT, OP_MV, OP_MUPD
  } op_t;

  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [2:0] i;
    logic [2:0] j;
    logic       first;
    logic       last;
    logic       neg;
    logic       half;
  } pipe_ctl_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic signed [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // position within an axis: 0 position, 1 velocity, 2 acceleration
  function automatic logic [1:0] sub3(input logic [2:0] r);
    logic [1:0] s;
    case (r) inside
      3'd1, 3'd4: s = 2'd1;
      3'd2, 3'd5: s = 2'd2;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] f_elem(input logic [2:0] r, input logic [2:0] c,
                                                input logic signed [31:0] dt,
                                                input logic signed [31:0] dt2,
                                                input logic signed [31:0] af);
    logic signed [31:0] v;
    v = '0;
    if (r == c) begin
      v = FX_ONE;
    end else if ((r >= 3'd3) == (c >= 3'd3)) begin
      case ({sub3(r), sub3(c)}) inside
        4'b0001, 4'b0110: v = dt;
        4'b0010:          v = dt2;
        4'b1001:          v = af;
        default:          v = '0;
      endcase
    end
    return v;
  endfunction

  function automatic logic signed [31:0] q_diag(input logic [2:0] r);
    logic signed [31:0] q;
    case (sub3(r))
      2'd1:    q = Q_VEL;
      2'd2:    q = Q_ACC;
      default: q = Q_POS;
    endcase
    return q;
  endfunction

  function automatic logic [COV_AW-1:0] idx6(input logic [2:0] r, input logic [2:0] c);
    return COV_AW'(6 * int'(r) + int'(c));
  endfunction

endpackage
`default_nettype wire

// File: hdl/kt2d_if.sv
// Valid/ready channel interfaces for the tracker: input, result and config write.
// Depends on kt2d_pkg for the config index width.
`default_nettype none
interface kt2d_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] obs_x;
  logic signed [31:0] obs_y;
  logic [7:0]         step_count;
  modport source (output valid, func, obs_x, obs_y, step_count, input ready);
  modport sink   (input valid, func, obs_x, obs_y, step_count, output ready);
endinterface

interface kt2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

interface kt2d_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kt2d_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/kt2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kt2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/kt2d_div.sv
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// Depends on kt2d_pkg.
`default_nettype none
module kt2d_div (
  input  logic                clk,
  input  logic                rst_n,
  input  kt2d_pkg::div_req_t  req,
  output logic                done,
  output logic signed [31:0]  quot
);
  import kt2d_pkg::*;

  logic              busy_r, done_r, neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r, quo_r;
  logic [31:0]       den_r, rem_r;
  logic [32:0]       num_mag, trial;
  logic [31:0]       den_mag;
  logic              fits;

  assign num_mag = req.num[32] ? 33'(-req.num) : 33'(req.num);
  assign den_mag = req.den[31] ? 32'(-req.den) : 32'(req.den);
  assign trial   = {rem_r, num_r[DIV_NW-1]};
  assign fits    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start && !busy_r) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= {num_mag, FRAC_BITS'(0)};
      den_r <= den_mag;
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= req.num[32] ^ req.den[31];
      cnt_r <= DIV_CW'(DIV_NW - 1);
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // saturate the signed quotient to 32 bits
  always_comb begin
    if (neg_r) begin
      if (quo_r > {{(DIV_NW-32){1'b0}}, 32'h8000_0000}) quot = 32'sh80000000;
      else quot = 32'(-quo_r);
    end else begin
      if (quo_r >= {{(DIV_NW-32){1'b0}}, 32'h8000_0000}) quot = 32'sh7fffffff;
      else quot = quo_r[31:0];
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire

// File: hdl/kalman_tracker_2d_const_accel_top.sv
// Two-axis constant-acceleration Kalman tracker, Q16.16, with saturation.
// Depends on kt2d_pkg, kt2d_if, kt2d_ram and kt2d_div.
//
// Channels: in_ch carries one item per beat (func 0: fold in observation
// obs_x/obs_y; func 1: look step_count steps ahead). out_ch returns one
// beat per item with pos_x/pos_y. cfg_ch writes registers 0..4 (initial x,
// initial y, time step, observation variance, velocity-to-acceleration
// coupling); writing an initial position also loads the mean directly.
// Write config only while no item is in flight.
//
// All multiplication runs through one pipelined multiply/round/accumulate unit
// (one 32x32 multiplier, one product per cycle) under a state sequencer,
// plus a bit-serial divider for the 2x2 inverse. An update item is
// dominated by three 6x6 matrix passes (FP, FTF, PMT), with four
// divisions between the second and third (skipped when the determinant is zero).
// A predict item runs one mean propagation pass per look-ahead step.
// in_ch.ready is high only while idle.
//
// Reset: the covariance RAM is loaded with the diagonal prior, then one
// covariance step runs with the reset values of the config registers;
// in_ch stays not ready until then. cfg_ch is always ready.
// A finished result sits in the output register; while out_ch stalls the
// block takes the next item but holds its result until the slot frees.
`default_nettype none
module kalman_tracker_2d_const_accel_top (
  input  logic       clk,
  input  logic       rst_n,
  kt2d_in_if.sink    in_ch,
  kt2d_out_if.source out_ch,
  kt2d_cfg_if.sink   cfg_ch
);
  import kt2d_pkg::*;

  typedef enum logic [14:0] {
    S_FILL  = 15'h0001,
    S_IDLE  = 15'h0002,
    S_DT2   = 15'h0004,
    S_FP    = 15'h0008,
    S_FTF   = 15'h0010,
    S_DET   = 15'h0020,
    S_DIV   = 15'h0040,
    S_GAIN  = 15'h0080,
    S_PMT   = 15'h0100,
    S_MV    = 15'h0200,
    S_INNOV = 15'h0400,
    S_MUPD  = 15'h0800,
    S_PLOOP = 15'h1000,
    S_PCOPY = 15'h2000,
    S_DONE  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic signed [31:0] accel_fb_r;
  logic [30:0]        time_step_r, meas_var_r;

  // mode and item registers
  logic               init_mode_r, func_r;
  logic [7:0]         cnt_r;
  logic signed [31:0] obs_x_r, obs_y_r;

  // architectural and working state
  logic signed [31:0] mean_r [6];
  logic signed [31:0] vsrc_r [6];
  logic signed [31:0] mp_r   [6];
  logic signed [31:0] k_r    [6][2];
  logic signed [31:0] inv_r  [4];
  logic signed [31:0] det_r, dt2_r, ix_r, iy_r;
  logic signed [31:0] t00_r, t03_r, t30_r, t33_r;

  // issue counters
  logic [2:0] ci_r, cj_r, ck_r;
  logic       issue_done_r;
  logic [2:0] fr_r, fc_r;

  // divider sequencing
  logic [1:0] dv_idx_r;
  logic       dv_wait_r;
  div_req_t   div_req;
  logic       div_done;
  logic signed [31:0] div_quot;

  // pipeline
  pipe_ctl_t          s0_ctl, s1_ctl_r, s2_ctl_r, s3_ctl_r, wb_ctl_r, wb_ctl_nxt;
  logic signed [31:0] s0_a, s0_b, s1_a_r, s1_b_r, s1_a;
  logic signed [63:0] prod_nxt, prod_r, rnd, shifted;
  logic signed [32:0] fx_nxt, fx_r;
  logic signed [35:0] acc_r, acc_nxt, acc_init;
  logic signed [31:0] wb_v, wb_q, wb_val;

  // RAMs
  logic              p_we, u_we, t_we;
  logic [COV_AW-1:0] p_waddr, rd_addr;
  logic [31:0]       p_wdata, p_rdata, u_rdata, t_rdata;

  // derived values
  op_t                op_cur;
  logic               in_op, issue_en, pipe_empty, op_done;
  logic [2:0]         i_last, j_last, k_last;
  logic signed [31:0] dt_use, r_use, af_use;
  logic signed [31:0] s00, s11, f_val, kv, m_val;
  logic [2:0]         f_row;
  logic [7:0]         steps_clamped;

  assign dt_use = init_mode_r ? TENTH : $signed({1'b0, time_step_r});
  assign r_use  = init_mode_r ? MEAS_VAR_RST : $signed({1'b0, meas_var_r});
  assign af_use = init_mode_r ? '0 : accel_fb_r;

  assign s00 = sat32(64'(t00_r) + 64'(r_use));
  assign s11 = sat32(64'(t33_r) + 64'(r_use));

  assign steps_clamped = (16'(in_ch.step_count) > 16'(PREDICT_STEPS_MAX)) ?
                         8'(PREDICT_STEPS_MAX) : in_ch.step_count;

  // ---------------------------------------------------------------- op decode
  always_comb begin
    in_op  = 1'b1;
    op_cur = OP_DT2;
    unique case (state_r)
      S_DT2:   op_cur = OP_DT2;
      S_FP:    op_cur = OP_FP;
      S_FTF:   op_cur = OP_FTF;
      S_DET:   op_cur = OP_DET;
      S_GAIN:  op_cur = OP_GAIN;
      S_PMT:   op_cur = OP_PMT;
      S_MV:    op_cur = OP_MV;
      S_MUPD:  op_cur = OP_MUPD;
      default: in_op  = 1'b0;
    endcase
  end

  always_comb begin
    i_last = 3'd5;
    j_last = 3'd5;
    k_last = 3'd5;
    case (op_cur)
      OP_DT2:  begin i_last = 3'd0; j_last = 3'd0; k_last = 3'd0; end
      OP_DET:  begin i_last = 3'd0; j_last = 3'd0; k_last = 3'd1; end
      OP_GAIN: begin j_last = 3'd1; k_last = 3'd1; end
      OP_MV:   j_last = 3'd0;
      OP_MUPD: begin j_last = 3'd0; k_last = 3'd1; end
      default: ;
    endcase
  end

  assign issue_en   = in_op && !issue_done_r;
  assign pipe_empty = !s1_ctl_r.valid && !s2_ctl_r.valid && !s3_ctl_r.valid && !wb_ctl_r.valid;
  assign op_done    = in_op && issue_done_r && pipe_empty;

  // ------------------------------------------------------- issue operands
  assign f_row = (op_cur == OP_FTF) ? cj_r : ci_r;
  assign f_val = f_elem(f_row, ck_r, dt_use, dt2_r, af_use);
  assign kv    = (ck_r == 3'd0) ? k_r[ci_r][0] : (ck_r == 3'd3) ? k_r[ci_r][1] : '0;
  assign m_val = sat32(64'((ci_r == ck_r) ? FX_ONE : 32'sd0) - 64'(kv));

  always_comb begin
    s0_a    = '0;
    s0_b    = '0;
    rd_addr = idx6(ck_r, cj_r);
    case (op_cur)
      OP_DT2: begin s0_a = dt_use; s0_b = dt_use; end
      OP_FP:  s0_b = f_val;
      OP_FTF: begin rd_addr = idx6(ci_r, ck_r); s0_b = f_val; end
      OP_DET: begin
        s0_a = ck_r[0] ? t03_r : s00;
        s0_b = ck_r[0] ? t30_r : s11;
      end
      OP_GAIN: begin
        rd_addr = idx6(ci_r, ck_r[0] ? 3'd3 : 3'd0);
        s0_b    = inv_r[{ck_r[0], cj_r[0]}];
      end
      OP_PMT: s0_b = m_val;
      OP_MV:  begin s0_a = f_val; s0_b = vsrc_r[ck_r]; end
      OP_MUPD: begin
        s0_a = k_r[ci_r][ck_r[0]];
        s0_b = ck_r[0] ? iy_r : ix_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    s0_ctl.valid = issue_en;
    s0_ctl.op    = op_cur;
    s0_ctl.i     = ci_r;
    s0_ctl.j     = cj_r;
    s0_ctl.first = (ck_r == 3'd0);
    s0_ctl.last  = (ck_r == k_last);
    s0_ctl.neg   = (op_cur == OP_DET) && ck_r[0];
    s0_ctl.half  = (op_cur == OP_DT2);
  end

  // only the last product of a sum reaches writeback
  always_comb begin
    wb_ctl_nxt       = s3_ctl_r;
    wb_ctl_nxt.valid = s3_ctl_r.valid && s3_ctl_r.last;
  end

  // ---------------------------------------------------- multiply / round
  always_comb begin
    case (s1_ctl_r.op) inside
      OP_FP:           s1_a = $signed(p_rdata);
      OP_FTF:          s1_a = $signed(u_rdata);
      OP_GAIN, OP_PMT: s1_a = $signed(t_rdata);
      default:         s1_a = s1_a_r;
    endcase
  end

  assign prod_nxt = s1_a * s1_b_r;

  // round half up and floor-shift; dt^2/2 uses one extra bit of shift
  assign rnd     = prod_r + (s2_ctl_r.half ? (64'sd1 <<< FRAC_BITS) : (64'sd1 <<< (FRAC_BITS - 1)));
  assign shifted = s2_ctl_r.half ? (rnd >>> (FRAC_BITS + 1)) : (rnd >>> FRAC_BITS);
  assign fx_nxt  = s2_ctl_r.neg ? -33'(sat32(shifted)) : 33'(sat32(shifted));

  assign acc_init = (s3_ctl_r.op == OP_MUPD) ? 36'(mp_r[s3_ctl_r.i]) : '0;
  assign acc_nxt  = (s3_ctl_r.first ? acc_init : acc_r) + 36'(fx_r);

  // writeback: saturate the exact sum, add process noise on the diagonal of the FTF pass
  assign wb_v   = sat32(64'(acc_r));
  assign wb_q   = sat32(64'(wb_v) + 64'(q_diag(wb_ctl_r.i)));
  assign wb_val = (wb_ctl_r.op == OP_FTF && wb_ctl_r.i == wb_ctl_r.j) ? wb_q : wb_v;

  // ---------------------------------------------------------------- RAMs
  assign p_we    = (state_r == S_FILL) || (wb_ctl_r.valid && wb_ctl_r.op == OP_PMT);
  assign p_waddr = (state_r == S_FILL) ? idx6(fr_r, fc_r) : idx6(wb_ctl_r.i, wb_ctl_r.j);
  assign p_wdata = (state_r == S_FILL) ?
                   ((fr_r == fc_r) ? ((sub3(fr_r) == 2'd0) ? PRIOR_POS : TENTH) : '0) : wb_val;
  assign u_we    = wb_ctl_r.valid && wb_ctl_r.op == OP_FP;
  assign t_we    = wb_ctl_r.valid && wb_ctl_r.op == OP_FTF;

  kt2d_ram #(.WIDTH(32), .DEPTH(COV_N)) u_ram_p (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(rd_addr), .rdata(p_rdata)
  );
  kt2d_ram #(.WIDTH(32), .DEPTH(COV_N)) u_ram_u (
    .clk, .we(u_we), .waddr(idx6(wb_ctl_r.i, wb_ctl_r.j)), .wdata(wb_val),
    .raddr(rd_addr), .rdata(u_rdata)
  );
  kt2d_ram #(.WIDTH(32), .DEPTH(COV_N)) u_ram_t (
    .clk, .we(t_we), .waddr(idx6(wb_ctl_r.i, wb_ctl_r.j)), .wdata(wb_val),
    .raddr(rd_addr), .rdata(t_rdata)
  );

  // ------------------------------------------------------------- divider
  always_comb begin
    div_req.start = (state_r == S_DIV) && (det_r != '0) && !dv_wait_r;
    div_req.den   = det_r;
    case (dv_idx_r)
      2'd0:    div_req.num = 33'(s11);
      2'd1:    div_req.num = -33'(t03_r);
      2'd2:    div_req.num = -33'(t30_r);
      default: div_req.num = 33'(s00);
    endcase
  end

  kt2d_div u_div (
    .clk, .rst_n, .req(div_req), .done(div_done), .quot(div_quot)
  );

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:  if (fr_r == 3'd5 && fc_r == 3'd5) state_nxt = S_DT2;
      S_IDLE:  if (in_ch.valid) state_nxt = S_DT2;
      S_DT2:   if (op_done) state_nxt = (init_mode_r || !func_r) ? S_FP : S_PLOOP;
      S_FP:    if (op_done) state_nxt = S_FTF;
      S_FTF:   if (op_done) state_nxt = S_DET;
      S_DET:   if (op_done) state_nxt = S_DIV;
      S_DIV:   if (det_r == '0 || (div_done && dv_idx_r == 2'd3)) state_nxt = S_GAIN;
      S_GAIN:  if (op_done) state_nxt = S_PMT;
      S_PMT:   if (op_done) state_nxt = init_mode_r ? S_IDLE : S_MV;
      S_MV:    if (op_done) state_nxt = func_r ? S_PCOPY : S_INNOV;
      S_INNOV: state_nxt = S_MUPD;
      S_MUPD:  if (op_done) state_nxt = S_DONE;
      S_PLOOP: state_nxt = (cnt_r == '0) ? S_DONE : S_MV;
      S_PCOPY: state_nxt = S_PLOOP;
      S_DONE:  if (!out_ch.valid || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      init_mode_r  <= 1'b1;
      func_r       <= 1'b0;
      fr_r         <= '0;
      fc_r         <= '0;
      ci_r         <= '0;
      cj_r         <= '0;
      ck_r         <= '0;
      issue_done_r <= 1'b0;
      dv_idx_r     <= '0;
      dv_wait_r    <= 1'b0;
      s1_ctl_r     <= '0;
      s2_ctl_r     <= '0;
      s3_ctl_r     <= '0;
      wb_ctl_r     <= '0;
      out_ch.valid <= 1'b0;
      time_step_r  <= TENTH[30:0];
      meas_var_r   <= MEAS_VAR_RST[30:0];
      accel_fb_r   <= '0;
      for (int n = 0; n < 6; n++) mean_r[n] <= '0;
    end else begin
      state_r <= state_nxt;

      // advance the prior fill
      if (state_r == S_FILL) begin
        if (fc_r == 3'd5) begin
          fc_r <= '0;
          fr_r <= fr_r + 3'd1;
        end else begin
          fc_r <= fc_r + 3'd1;
        end
      end

      // advance k innermost, then j, then i
      if (issue_en) begin
        if (ck_r == k_last) begin
          ck_r <= '0;
          if (cj_r == j_last) begin
            cj_r <= '0;
            if (ci_r == i_last) begin
              ci_r         <= '0;
              issue_done_r <= 1'b1;
            end else begin
              ci_r <= ci_r + 3'd1;
            end
          end else begin
            cj_r <= cj_r + 3'd1;
          end
        end else begin
          ck_r <= ck_r + 3'd1;
        end
      end else if (op_done) begin
        issue_done_r <= 1'b0;
      end

      if (state_r == S_PMT && op_done) init_mode_r <= 1'b0;
      if (in_ch.valid && in_ch.ready) func_r <= in_ch.func;

      // one division at a time, four quotients
      if (div_req.start) dv_wait_r <= 1'b1;
      if (div_done) begin
        dv_wait_r <= 1'b0;
        dv_idx_r  <= dv_idx_r + 2'd1;
      end

      s1_ctl_r <= s0_ctl;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      wb_ctl_r <= wb_ctl_nxt;

      if (wb_ctl_r.valid && wb_ctl_r.op == OP_MUPD) mean_r[wb_ctl_r.i] <= wb_val;

      // hold the result until the receiver takes the beat
      if (state_r == S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_INIT_POS_X: mean_r[0]   <= $signed(cfg_ch.data);
          CFG_INIT_POS_Y: mean_r[3]   <= $signed(cfg_ch.data);
          CFG_TIME_STEP:  time_step_r <= cfg_ch.data[30:0];
          CFG_MEAS_VAR:   meas_var_r  <= cfg_ch.data[30:0];
          CFG_ACCEL_FB:   accel_fb_r  <= $signed(cfg_ch.data);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_a_r <= s0_a;
    s1_b_r <= s0_b;
    prod_r <= prod_nxt;
    fx_r   <= fx_nxt;
    if (s3_ctl_r.valid) acc_r <= acc_nxt;

    if (in_ch.valid && in_ch.ready) begin
      obs_x_r <= in_ch.obs_x;
      obs_y_r <= in_ch.obs_y;
      cnt_r   <= steps_clamped;
      for (int n = 0; n < 6; n++) vsrc_r[n] <= mean_r[n];
    end

    if (state_r == S_PCOPY) begin
      for (int n = 0; n < 6; n++) vsrc_r[n] <= mp_r[n];
      cnt_r <= cnt_r - 8'd1;
    end

    if (state_r == S_INNOV) begin
      ix_r <= sat32(64'(obs_x_r) - 64'(mp_r[0]));
      iy_r <= sat32(64'(obs_y_r) - 64'(mp_r[3]));
    end

    if (state_r == S_DIV) begin
      if (det_r == '0) begin
        for (int n = 0; n < 4; n++) inv_r[n] <= '0;
      end else if (div_done) begin
        inv_r[dv_idx_r] <= div_quot;
      end
    end

    if (wb_ctl_r.valid) begin
      case (wb_ctl_r.op)
        OP_DT2:  dt2_r <= wb_val;
        OP_DET:  det_r <= wb_val;
        OP_GAIN: k_r[wb_ctl_r.i][wb_ctl_r.j[0]] <= wb_val;
        OP_MV:   mp_r[wb_ctl_r.i] <= wb_val;
        OP_FTF: begin
          // keep the innovation block of T for the 2x2 inverse
          if (wb_ctl_r.i == 3'd0 && wb_ctl_r.j == 3'd0) t00_r <= wb_val;
          if (wb_ctl_r.i == 3'd0 && wb_ctl_r.j == 3'd3) t03_r <= wb_val;
          if (wb_ctl_r.i == 3'd3 && wb_ctl_r.j == 3'd0) t30_r <= wb_val;
          if (wb_ctl_r.i == 3'd3 && wb_ctl_r.j == 3'd3) t33_r <= wb_val;
        end
        default: ;
      endcase
    end

    if (state_r == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.pos_x <= func_r ? vsrc_r[0] : mean_r[0];
      out_ch.pos_y <= func_r ? vsrc_r[3] : mean_r[3];
    end
  end

endmodule
`default_nettype wire
